// ===== design/fpr_pkg.sv =====
// Package with codes, header bytes and the heartbeat table of the framed packet receiver.
`default_nettype none

package fpr_pkg;

    localparam int STORE_DEPTH_DEFAULT = 256;

    localparam logic [7:0] HDR_FIRST      = 8'h4E;
    localparam logic [7:0] HDR_SECOND     = 8'h52;
    localparam logic [7:0] TYPE_HEARTBEAT = 8'h00;
    localparam logic [7:0] TYPE_PACKET    = 8'h01;

    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_TX     = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] BEAT_COUNT_LAST = 2'd2;

    // Heartbeat answer: the header bytes followed by the heartbeat type.
    function automatic logic [7:0] beat_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = HDR_FIRST;
            2'd1:    b = HDR_SECOND;
            default: b = TYPE_HEARTBEAT;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== design/framed_packet_receiver.sv =====
// Framed packet receiver: header matcher, packet buffer memory and result stages.
//
// Usage. Each input beat carries an opcode: 0 hands in one received serial byte,
// 1 reads one entry of the 256-byte packet buffer, 2 releases a completed packet.
// Bytes are matched against the header 'N','R' and a type byte; type 0 answers
// with the three heartbeat bytes 4E 52 00, type 1 starts storing a packet whose
// length is the first stored byte. Every input beat causes one result beat, and
// a heartbeat causes three, the final one marked by last. Every result also
// reports the receiving and complete flags and the write position.
// Path: a result goes from the accepted input beat through the buffer read and
// middle stage register, then through the output register. Throughput is one
// input beat per cycle while the output is ready; a heartbeat keeps the output
// busy for its three bytes, during which one more input beat can wait in
// the middle stage. The buffer is a synchronous single-write, single-read memory;
// writes and reads happen at the accept edge, so a read right after a write to
// the same entry already sees the new byte.
// Reset clears the matcher, the flags, the write position and both stages; the
// buffer contents are not cleared and entries never written read as garbage.
// When the receiver stalls, the output beat holds, the middle stage fills and
// in_ready then falls until the output drains.
`default_nettype none

module framed_packet_receiver #(
    parameter int STORE_DEPTH = fpr_pkg::STORE_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] opcode,
    input  wire logic [7:0] rx_byte,
    input  wire logic [7:0] read_index,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      value,
    output logic            last,
    output logic            fail_safe_reset,
    output logic            receiving,
    output logic            packet_complete,
    output logic [7:0]      bytes_stored
);
    import fpr_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // Header matcher states.
    localparam logic [1:0] HS_IDLE    = 2'd0;
    localparam logic [1:0] HS_SEEN_N  = 2'd1;
    localparam logic [1:0] HS_SEEN_NR = 2'd2;

    // Architectural state.
    logic [1:0] stage_reg, stage_next;
    logic       recv_reg, recv_next;
    logic       comp_reg, comp_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;

    // Packet buffer and its registered read port.
    logic [7:0] store [STORE_DEPTH];
    logic [7:0] rd_data_reg;
    logic       mem_we;

    // Middle stage: one result waiting behind the output register.
    logic       a_valid_reg;
    logic [1:0] a_kind_reg;
    logic [7:0] a_value_reg;
    logic       a_read_reg;
    logic       a_beat_reg;
    logic       a_pulse_reg;
    logic       a_recv_reg;
    logic       a_comp_reg;
    logic [7:0] a_pos_reg;

    // Output register.
    logic       o_valid_reg;
    logic [1:0] o_kind_reg;
    logic [7:0] o_value_reg;
    logic       o_last_reg;
    logic       o_pulse_reg;
    logic       o_recv_reg;
    logic       o_comp_reg;
    logic [7:0] o_pos_reg;
    logic [1:0] o_cnt_reg;

    // Result of the beat being accepted.
    logic [1:0] res_kind;
    logic [7:0] res_value;
    logic       res_read;
    logic       res_beat;
    logic       res_pulse;

    logic in_fire;
    logic out_fire;
    logic a_move;
    logic [1:0] cnt_inc;

    assign out_fire = o_valid_reg && out_ready;
    // The middle stage moves on when the output is empty or its final beat leaves.
    assign a_move   = a_valid_reg && (!o_valid_reg || (out_ready && o_last_reg));
    assign in_ready = !a_valid_reg || a_move;
    assign in_fire  = in_valid && in_ready;
    assign cnt_inc  = o_cnt_reg + 2'd1;

    // Next-state logic of the matcher, flags and write position.
    always_comb
    begin
        stage_next = stage_reg;
        recv_next  = recv_reg;
        comp_next  = comp_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        mem_we     = 1'b0;
        res_kind   = KIND_STATUS;
        res_value  = 8'h00;
        res_read   = 1'b0;
        res_beat   = 1'b0;
        res_pulse  = 1'b0;
        case (opcode)
            OP_READ:
            begin
                res_kind = KIND_READ;
                res_read = 1'b1;
            end
            OP_RELEASE:
            begin
                comp_next = 1'b0;
            end
            OP_RX:
            begin
                if (!comp_reg)
                begin
                    if (recv_reg)
                    begin
                        // Payload byte: store it, the first one is the length.
                        mem_we = in_fire;
                        if (pos_reg == 8'h00)
                        begin
                            len_next = rx_byte;
                        end
                        if (pos_reg != 8'h00 && pos_reg == len_reg)
                        begin
                            recv_next = 1'b0;
                            comp_next = 1'b1;
                        end
                        pos_next = pos_reg + 8'd1;
                    end
                    else
                    begin
                        case (stage_reg)
                            HS_IDLE:
                            begin
                                stage_next = (rx_byte == HDR_FIRST) ? HS_SEEN_N : HS_IDLE;
                            end
                            HS_SEEN_N:
                            begin
                                stage_next = (rx_byte == HDR_SECOND) ? HS_SEEN_NR : HS_IDLE;
                            end
                            HS_SEEN_NR:
                            begin
                                // Any type byte pulses the fail-safe reset.
                                stage_next = HS_IDLE;
                                res_pulse  = 1'b1;
                                if (rx_byte == TYPE_HEARTBEAT)
                                begin
                                    res_beat  = 1'b1;
                                    res_kind  = KIND_TX;
                                    res_value = beat_byte(2'd0);
                                end
                                else if (rx_byte == TYPE_PACKET)
                                begin
                                    pos_next  = 8'h00;
                                    recv_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                stage_next = HS_IDLE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= HS_IDLE;
            recv_reg  <= 1'b0;
            comp_reg  <= 1'b0;
            pos_reg   <= 8'h00;
            len_reg   <= 8'h00;
        end
        else if (in_fire)
        begin
            stage_reg <= stage_next;
            recv_reg  <= recv_next;
            comp_reg  <= comp_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
        end
    end

    // Buffer memory: write and read both at the accept edge.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[pos_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (in_fire && opcode == OP_READ)
        begin
            rd_data_reg <= store[read_index[ADDR_W-1:0]];
        end
    end

    // Middle stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_kind_reg  <= res_kind;
            a_value_reg <= res_value;
            a_read_reg  <= res_read;
            a_beat_reg  <= res_beat;
            a_pulse_reg <= res_pulse;
            a_recv_reg  <= recv_next;
            a_comp_reg  <= comp_next;
            a_pos_reg   <= pos_next;
        end
    end

    // Output register; a heartbeat steps through its three bytes here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            o_last_reg  <= 1'b0;
            o_cnt_reg   <= 2'd0;
        end
        else if (out_fire && !o_last_reg)
        begin
            o_cnt_reg  <= cnt_inc;
            o_last_reg <= (cnt_inc == BEAT_COUNT_LAST);
        end
        else if (a_move)
        begin
            o_valid_reg <= 1'b1;
            o_last_reg  <= !a_beat_reg;
            o_cnt_reg   <= 2'd0;
        end
        else if (out_fire)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire && !o_last_reg)
        begin
            o_value_reg <= beat_byte(cnt_inc);
        end
        else if (a_move)
        begin
            o_kind_reg  <= a_kind_reg;
            o_value_reg <= a_read_reg ? rd_data_reg : a_value_reg;
            o_pulse_reg <= a_pulse_reg;
            o_recv_reg  <= a_recv_reg;
            o_comp_reg  <= a_comp_reg;
            o_pos_reg   <= a_pos_reg;
        end
    end

    assign out_valid       = o_valid_reg;
    assign kind            = o_kind_reg;
    assign value           = o_value_reg;
    assign last            = o_last_reg;
    assign fail_safe_reset = o_pulse_reg;
    assign receiving       = o_recv_reg;
    assign packet_complete = o_comp_reg;
    assign bytes_stored    = o_pos_reg;

endmodule

`default_nettype wire

// ===== verif/tb_framed_packet_receiver.sv =====
// Self-checking testbench for the framed packet receiver: header matching, packet storage, reads.
`timescale 1ns / 1ps

module tb_framed_packet_receiver;

    import fpr_pkg::*;

    // Opcode 3 is not a defined command; the block must answer it with a plain status beat.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // A type byte that is neither heartbeat nor packet start.
    localparam logic [7:0] TYPE_UNKNOWN = 8'h7F;
    // Byte used to push the header matcher back to idle before a new sequence starts.
    localparam logic [7:0] FLUSH_BYTE = 8'h33;
    // The heartbeat answer, first byte in the top lane.
    localparam logic [23:0] HEARTBEAT_SEQ = {HDR_FIRST, HDR_SECOND, TYPE_HEARTBEAT};
    localparam int RANDOM_BUDGET = 160;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic [7:0] index;
    } beat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
        logic       pulse;
        logic       rx_on;
        logic       done;
        logic [7:0] stored;
    } answer_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] opcode = OP_RX;
    logic [7:0] rx_byte = 8'h00;
    logic [7:0] read_index = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
    logic       fail_safe_reset;
    logic       receiving;
    logic       packet_complete;
    logic [7:0] bytes_stored;

    framed_packet_receiver uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .rx_byte         (rx_byte),
        .read_index      (read_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .value           (value),
        .last            (last),
        .fail_safe_reset (fail_safe_reset),
        .receiving       (receiving),
        .packet_complete (packet_complete),
        .bytes_stored    (bytes_stored)
    );

    always #5 clk = ~clk;

    // Shadow of the receiver: header matcher, flags, write position, length byte and the
    // packet buffer. The filled map records which buffer entries hold a known byte, so that
    // the stimulus never reads an entry whose contents are undefined.
    logic [1:0] hdr_stage = 2'd0;
    logic       rx_on = 1'b0;
    logic       done_flag = 1'b0;
    logic [7:0] wr_pos = 8'd0;
    logic [7:0] len_byte = 8'd0;
    logic [7:0] store [0:255];
    bit         filled [0:255];

    beat_t   beat_q[$];       // input beats not yet presented to the block
    answer_t due_answers[$];  // result beats predicted but not yet seen
    int      mismatch_count = 0;
    int      issued = 0;
    bit      big_fill_due = 1'b1;
    bit      beat_taken = 1'b0;

    // Appends one expected result beat; the flag and position fields reflect the shadow
    // state after the input beat has been applied.
    task automatic queue_answer(input logic [1:0] k, input logic [7:0] v, input logic l,
                                input logic p);
        answer_t a;
        a.kind = k;
        a.value = v;
        a.last = l;
        a.pulse = p;
        a.rx_on = rx_on;
        a.done = done_flag;
        a.stored = wr_pos;
        due_answers.push_back(a);
    endtask

    // Applies one accepted input beat to the shadow state and queues its result beats.
    task automatic decode_beat(input logic [1:0] op, input logic [7:0] b, input logic [7:0] idx);
        int k;
        if (op == OP_READ)
        begin
            queue_answer(KIND_READ, store[idx], 1'b1, 1'b0);
        end
        else if (op == OP_RELEASE)
        begin
            done_flag = 1'b0;
            queue_answer(KIND_STATUS, 8'h00, 1'b1, 1'b0);
        end
        else if (op != OP_RX || done_flag)
        begin
            // Undefined opcodes and bytes arriving while a packet is held are dropped.
            queue_answer(KIND_STATUS, 8'h00, 1'b1, 1'b0);
        end
        else if (rx_on)
        begin
            store[wr_pos] = b;
            filled[wr_pos] = 1'b1;
            if (wr_pos == 8'd0)
                len_byte = b;
            // The packet is complete when the position of this byte equals the length.
            // A zero length never matches, so the position wraps and keeps overwriting.
            if (wr_pos != 8'd0 && wr_pos == len_byte)
            begin
                rx_on = 1'b0;
                done_flag = 1'b1;
            end
            wr_pos = wr_pos + 8'd1;
            queue_answer(KIND_STATUS, 8'h00, 1'b1, 1'b0);
        end
        else if (hdr_stage == 2'd0 && b == HDR_FIRST)
        begin
            hdr_stage = 2'd1;
            queue_answer(KIND_STATUS, 8'h00, 1'b1, 1'b0);
        end
        else if (hdr_stage == 2'd1 && b == HDR_SECOND)
        begin
            hdr_stage = 2'd2;
            queue_answer(KIND_STATUS, 8'h00, 1'b1, 1'b0);
        end
        else if (hdr_stage == 2'd2)
        begin
            // Any type byte pulses the fail-safe reset and sends the matcher back to idle.
            hdr_stage = 2'd0;
            if (b == TYPE_HEARTBEAT)
            begin
                for (k = 0; k < 3; k++)
                    queue_answer(KIND_TX, HEARTBEAT_SEQ[23 - 8 * k -: 8], k == 2, 1'b1);
            end
            else
            begin
                if (b == TYPE_PACKET)
                begin
                    wr_pos = 8'd0;
                    rx_on = 1'b1;
                end
                queue_answer(KIND_STATUS, 8'h00, 1'b1, 1'b1);
            end
        end
        else
        begin
            // A byte that breaks the header, including a second 'N', restarts from idle.
            hdr_stage = 2'd0;
            queue_answer(KIND_STATUS, 8'h00, 1'b1, 1'b0);
        end
    endtask

    task automatic push_beat(input logic [1:0] op, input logic [7:0] b, input logic [7:0] idx);
        beat_t t;
        t.op = op;
        t.data = b;
        t.index = idx;
        beat_q.push_back(t);
        issued++;
    endtask

    // A received serial byte; the unused index field carries noise.
    task automatic push_rx(input logic [7:0] b);
        push_beat(OP_RX, b, 8'($urandom));
    endtask

    // Reads an entry that was written before this sequence was built. Nothing is
    // pushed while the buffer is still entirely unwritten.
    task automatic push_read_of_known();
        int start;
        int i;
        start = $urandom_range(0, 255);
        for (i = 0; i < 256; i++)
        begin
            if (filled[(start + i) % 256])
            begin
                push_beat(OP_READ, 8'($urandom), 8'((start + i) % 256));
                return;
            end
        end
    endtask

    task automatic push_release();
        push_beat(OP_RELEASE, 8'($urandom), 8'($urandom));
    endtask

    // Packet payload bytes, with the odd read or harmless release mixed in.
    task automatic push_payload(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                push_read_of_known();
            if ($urandom_range(0, 19) == 0)
                push_release();
            push_rx(8'($urandom));
        end
    endtask

    // Builds one sequence of beats starting from the current shadow state. It is only
    // called while the block is idle, so the shadow state is the state of the block.
    task automatic build_episode();
        int n;
        int i;
        int len;
        int pick;
        if (done_flag)
        begin
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
                push_read_of_known();
            if ($urandom_range(0, 2) == 0)
                push_rx(8'($urandom));
            if ($urandom_range(0, 5) == 0)
                push_beat(OP_UNUSED, 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 4) != 0)
                push_release();
        end
        else if (rx_on)
        begin
            if (wr_pos == 8'd0)
            begin
                // A fresh length byte. The first time round it is the largest length,
                // which writes every entry of the buffer.
                if (big_fill_due)
                begin
                    big_fill_due = 1'b0;
                    push_rx(8'hFF);
                    push_payload(255);
                    issued -= 256;
                end
                else
                begin
                    len = $urandom_range(1, 8);
                    push_rx(8'(len));
                    push_payload(len);
                end
            end
            else if (len_byte != 8'd0 && wr_pos <= len_byte)
            begin
                push_payload(int'(len_byte) - int'(wr_pos) + 1);
            end
            else
            begin
                // The length cannot be reached any more: fill up to the wrap, where the
                // next byte rewrites the length. Long fill-ups do not use up the budget.
                n = 256 - int'(wr_pos);
                push_payload(n);
                if (n > 64)
                    issued -= n;
            end
        end
        else if (hdr_stage != 2'd0)
        begin
            push_rx(FLUSH_BYTE);
        end
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 3)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                push_rx(HDR_FIRST);
                push_rx(HDR_SECOND);
                push_rx(TYPE_PACKET);
                push_rx(8'(len));
                // Now and then the packet is cut short and finished by a later sequence.
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
                push_payload(n);
                if (n == len && $urandom_range(0, 2) == 0)
                begin
                    push_rx(8'($urandom));
                    push_read_of_known();
                end
            end
            else if (pick == 4)
            begin
                push_rx(HDR_FIRST);
                push_rx(HDR_SECOND);
                push_rx(TYPE_HEARTBEAT);
            end
            else if (pick == 5)
            begin
                push_rx(HDR_FIRST);
                push_rx(HDR_SECOND);
                push_rx(8'($urandom_range(TYPE_PACKET + 1, 255)));
            end
            else if (pick == 6)
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    push_rx(8'($urandom));
            end
            else if (pick == 7)
            begin
                // Broken headers: a repeated 'N', or 'N' followed by the wrong byte.
                push_rx(HDR_FIRST);
                if ($urandom_range(0, 1) == 0)
                begin
                    push_rx(HDR_FIRST);
                    push_rx(HDR_SECOND);
                    push_rx(TYPE_PACKET);
                end
                else
                begin
                    push_rx(8'($urandom_range(0, 255)) ^ (HDR_SECOND & 8'h00) | 8'h80);
                end
            end
            else if (pick == 8)
            begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    push_read_of_known();
                push_release();
            end
            else
            begin
                push_beat(OP_UNUSED, 8'($urandom), 8'($urandom));
                push_release();
            end
        end
    endtask

    // Waits until every beat has been presented, accepted and answered, then lets the
    // two-stage pipeline settle.
    task automatic wait_idle();
        while (beat_q.size() != 0 || in_valid || due_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Monitor: checks result beats against the oldest prediction and feeds every accepted
    // input beat into the shadow. Both sides are sampled at the rising edge.
    always @(posedge clk)
    begin : monitor
        answer_t exp_a;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_answers.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result beat kind %0d value %02h",
                                 $realtime, kind, value);
                end
                else
                begin
                    exp_a = due_answers.pop_front();
                    if (kind !== exp_a.kind || value !== exp_a.value || last !== exp_a.last
                        || fail_safe_reset !== exp_a.pulse || receiving !== exp_a.rx_on
                        || packet_complete !== exp_a.done || bytes_stored !== exp_a.stored)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: mismatch exp kind %0d value %02h last %0d fsr %0d",
                                      " rcv %0d cmpl %0d stored %02h / got kind %0d value %02h",
                                      " last %0d fsr %0d rcv %0d cmpl %0d stored %02h"},
                                     $realtime, exp_a.kind, exp_a.value, exp_a.last,
                                     exp_a.pulse, exp_a.rx_on, exp_a.done, exp_a.stored,
                                     kind, value, last, fail_safe_reset, receiving,
                                     packet_complete, bytes_stored);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                decode_beat(opcode, rx_byte, read_index);
                beat_taken = 1'b1;
            end
        end
    end

    // Driver: presents beats at the falling edge in bursts of random length separated by
    // random gaps. A beat stays on the bus until the monitor has seen it accepted.
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge clk)
    begin : drive_inputs
        logic  next_valid;
        beat_t cur;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (beat_taken)
            begin
                next_valid = 1'b0;
                beat_taken = 1'b0;
            end
            if (!next_valid && beat_q.size() != 0)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else
                begin
                    cur = beat_q.pop_front();
                    opcode <= cur.op;
                    rx_byte <= cur.data;
                    read_index <= cur.index;
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // One burst in four is a long run with no gap at all.
                        if ($urandom_range(0, 3) == 0)
                        begin
                            gap_left = 0;
                            burst_left = $urandom_range(20, 60);
                        end
                        else
                        begin
                            gap_left = $urandom_range(1, 6);
                            burst_left = $urandom_range(1, 10);
                        end
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // Receiver back-pressure: a 32-bit ready pattern replayed bit by bit. Every so often
    // a new pattern is drawn, always ready, mostly ready, half ready or mostly stalled.
    logic [31:0] ready_pat = '1;
    logic [4:0]  pat_pos = 5'd0;
    int          pat_left = 0;

    always @(negedge clk)
    begin
        if (pat_left == 0)
        begin
            pat_left = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0:       ready_pat = '1;
                1:       ready_pat = $urandom | $urandom;
                2:       ready_pat = $urandom;
                default: ready_pat = $urandom & $urandom;
            endcase
        end
        else
        begin
            pat_left--;
        end
        out_ready <= ready_pat[pat_pos];
        pat_pos <= pat_pos + 5'd1;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part. Unused fields carry their extremes on the first release and on the
        // undefined opcode.
        push_beat(OP_RELEASE, 8'hFF, 8'hFF);     // release with nothing complete
        push_beat(OP_UNUSED, 8'h00, 8'h00);      // undefined opcode
        push_rx(8'hFF);
        push_rx(8'h00);
        push_rx(HDR_FIRST);                      // a second 'N' does not restart the header
        push_rx(HDR_FIRST);
        push_rx(HDR_SECOND);
        push_rx(HDR_FIRST);                      // heartbeat
        push_rx(HDR_SECOND);
        push_rx(TYPE_HEARTBEAT);
        push_rx(HDR_FIRST);                      // unknown type byte
        push_rx(HDR_SECOND);
        push_rx(TYPE_UNKNOWN);
        push_rx(HDR_FIRST);                      // two-byte packet, completes
        push_rx(HDR_SECOND);
        push_rx(TYPE_PACKET);
        push_rx(8'd2);
        push_rx(8'hA5);
        push_rx(8'h5A);
        push_beat(OP_READ, 8'h00, 8'd0);
        push_beat(OP_READ, 8'hFF, 8'd2);
        push_rx(HDR_FIRST);                      // dropped while the packet is held
        push_release();
        push_release();
        push_rx(HDR_FIRST);                      // zero length: never completes, wraps
        push_rx(HDR_SECOND);
        push_rx(TYPE_PACKET);
        push_rx(8'h00);
        push_rx(8'h11);
        push_rx(8'h22);
        push_rx(8'h33);
        wait_idle();

        // Random part, one sequence at a time from a known idle state. The first two
        // sequences finish the wrapped zero-length packet and fill the whole buffer.
        issued = 0;
        while (issued < RANDOM_BUDGET)
        begin
            build_episode();
            wait_idle();
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && due_answers.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== framed_packet_receiver.f =====
design/fpr_pkg.sv
design/framed_packet_receiver.sv
verif/tb_framed_packet_receiver.sv
